// ----- rtl/pfb_pkg.sv -----
// Shared constants for the page frame buffer line fill unit.
package pfb_pkg;

    // Command codes carried on the input tuser
    localparam logic [1:0] CMD_HLINE = 2'd0;
    localparam logic [1:0] CMD_VLINE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Colour modes
    localparam logic [1:0] MODE_SET = 2'd0;
    localparam logic [1:0] MODE_CLR = 2'd1;
    localparam logic [1:0] MODE_INV = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    // Register reset values
    localparam logic [7:0] WIDTH_RST  = 8'd128;
    localparam logic [6:0] HEIGHT_RST = 7'd64;

    // Field widths
    localparam int COORD_W     = 16;
    localparam int MODE_W      = 2;
    localparam int CMD_W       = 2;
    localparam int READ_ADDR_W = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 64;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 16;

    // Clipping is done at full precision on sign-extended coordinates
    localparam int CLIP_W = 18;

    // Width of the address arithmetic; covers the largest store (4096 bytes)
    localparam int ADDR_SUM_W = 14;

endpackage

// ----- rtl/page_framebuffer_line_fill_unit.sv -----
// Page frame buffer line fill unit: draws clipped lines into a paged monochrome store.
//
// The store holds one byte per column per 8-row page (byte index page * width + column,
// bit k is row page * 8 + k) and is cleared after reset by a pass that writes one byte a
// cycle over all MAX_WIDTH * ceil(MAX_HEIGHT / 8) bytes (1024 by default); no command is taken
// until it ends, configuration writes are taken throughout. Each command gives one result
// beat. A line that draws n bytes (columns for a horizontal line, pages for a vertical
// one) reads and then writes back each byte in turn through the store before ready
// returns. One command is in work at a time; the result register lets the next command be
// accepted while a result waits to be taken.
module page_framebuffer_line_fill_unit #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Command stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: x_pos[15:0], y_pos[31:16], length[47:32], color_mode[49:48],
    //        read_address[59:50], zero[63:60]
    input  logic [pfb_pkg::S_TDATA_W-1:0]      s_tdata,
    // tuser: cmd[1:0]
    input  logic [pfb_pkg::S_TUSER_W-1:0]      s_tuser,
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: read_data[7:0], drew_any[8], zero[15:9]
    output logic [pfb_pkg::M_TDATA_W-1:0]      m_tdata,
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pfb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pfb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import pfb_pkg::*;

    localparam int PAGES = (MAX_HEIGHT + 7) / 8;
    localparam int DEPTH = MAX_WIDTH * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int RDW   = (AW > READ_ADDR_W) ? AW : READ_ADDR_W;
    localparam logic [8:0] MAXW9 = 9'(MAX_WIDTH);
    localparam logic [7:0] MAXH8 = 8'(MAX_HEIGHT);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLIP,
        ST_BASE,
        ST_RD,
        ST_MOD,
        ST_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [7:0]                 width_reg, width_next;
    logic [6:0]                 height_reg, height_next;
    logic [CMD_W-1:0]           cmd_reg, cmd_next;
    logic [MODE_W-1:0]          mode_reg, mode_next;
    logic signed [COORD_W-1:0]  x_reg, x_next;
    logic signed [COORD_W-1:0]  y_reg, y_next;
    logic signed [COORD_W-1:0]  len_reg, len_next;
    logic [READ_ADDR_W-1:0]     ra_reg, ra_next;
    logic [7:0]                 cur_reg, cur_next;
    logic [7:0]                 end_reg, end_next;
    logic [7:0]                 oth_reg, oth_next;
    logic [AW-1:0]              addr_reg, addr_next;
    logic                       rd_ok_reg, rd_ok_next;
    logic [7:0]                 res_data_reg, res_data_next;
    logic                       res_drew_reg, res_drew_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [7:0]                 m_data_reg, m_data_next;
    logic                       m_drew_reg, m_drew_next;

    logic [7:0]                 w_eff;
    logic [7:0]                 h_eff;
    logic                       is_h;
    logic                       s_accept;
    logic signed [CLIP_W-1:0]   p_s, o_s, len_s, end_s, start_s, lim_p_s, lim_o_s, hi_s;
    logic                       draw_ok;
    logic [4:0]                 page;
    logic [7:0]                 col;
    logic [ADDR_SUM_W-1:0]      base_sum;
    logic [ADDR_SUM_W-1:0]      step;
    logic [ADDR_SUM_W-1:0]      addr_sum;
    logic [RDW-1:0]             ra_wide;
    logic [8:0]                 top8;
    logic [3:0]                 lo;
    logic [3:0]                 hi;
    logic [7:0]                 mask;
    logic [8:0]                 cur_adv;
    logic [7:0]                 mod_data;
    logic                       ram_we;
    logic                       ram_re;
    logic [7:0]                 ram_wdata;
    logic [7:0]                 ram_rdata;

    // Limit the display size to the store size
    assign w_eff = ({1'b0, width_reg} > MAXW9) ? MAXW9[7:0] : width_reg;
    assign h_eff = ({1'b0, height_reg} > MAXH8) ? MAXH8 : {1'b0, height_reg};
    assign is_h  = (cmd_reg == CMD_HLINE);

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Clip along the line and across it; one adder serves both line kinds
    always_comb
    begin
        p_s     = is_h ? {{2{x_reg[COORD_W-1]}}, x_reg} : {{2{y_reg[COORD_W-1]}}, y_reg};
        o_s     = is_h ? {{2{y_reg[COORD_W-1]}}, y_reg} : {{2{x_reg[COORD_W-1]}}, x_reg};
        len_s   = {{2{len_reg[COORD_W-1]}}, len_reg};
        lim_p_s = is_h ? {10'd0, w_eff} : {10'd0, h_eff};
        lim_o_s = is_h ? {10'd0, h_eff} : {10'd0, w_eff};
        end_s   = p_s + len_s;
        start_s = p_s[CLIP_W-1] ? '0 : p_s;
        hi_s    = (end_s > lim_p_s) ? lim_p_s : end_s;
        draw_ok = ((cmd_reg == CMD_HLINE) || (cmd_reg == CMD_VLINE))
               && ((mode_reg == MODE_SET) || (mode_reg == MODE_CLR) || (mode_reg == MODE_INV))
               && !o_s[CLIP_W-1] && (o_s < lim_o_s) && (hi_s > start_s);
    end

    // First byte address: page times width plus column
    assign page     = is_h ? oth_reg[7:3] : cur_reg[7:3];
    assign col      = is_h ? cur_reg : oth_reg;
    assign base_sum = ({{(ADDR_SUM_W-5){1'b0}}, page} * {{(ADDR_SUM_W-8){1'b0}}, w_eff})
                    + {{(ADDR_SUM_W-8){1'b0}}, col};

    // Shared address stepper: one byte along a row and in the clearing pass, one page down a column
    assign step     = ((state_reg == ST_CLEAR) || is_h) ? ADDR_SUM_W'(1)
                                                        : {{(ADDR_SUM_W-8){1'b0}}, w_eff};
    assign addr_sum = {{(ADDR_SUM_W-AW){1'b0}}, addr_reg} + step;
    assign ra_wide  = RDW'(ra_reg);

    // Byte mask: one row bit across, head/solid/tail down
    always_comb
    begin
        top8 = {1'b0, cur_reg[7:3], 3'b000} + 9'd8;
        lo   = {1'b0, cur_reg[2:0]};
        hi   = ({1'b0, end_reg} >= top8) ? 4'd8 : {1'b0, end_reg[2:0]};
        if (is_h)
        begin
            mask = 8'h01 << oth_reg[2:0];
        end
        else
        begin
            mask = (8'hFF << lo) & (8'hFF >> (4'd8 - hi));
        end
        cur_adv = is_h ? ({1'b0, cur_reg} + 9'd1) : top8;
    end

    // Apply the colour mode
    always_comb
    begin
        case (mode_reg)
            MODE_SET: mod_data = ram_rdata | mask;
            MODE_CLR: mod_data = ram_rdata & ~mask;
            MODE_INV: mod_data = ram_rdata ^ mask;
            default:  mod_data = ram_rdata;
        endcase
    end

    assign ram_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_MOD) && (cmd_reg != CMD_READ));
    assign ram_wdata = (state_reg == ST_CLEAR) ? 8'h00 : mod_data;
    assign ram_re    = (state_reg == ST_RD);

    pfb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        cmd_next      = cmd_reg;
        mode_next     = mode_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        len_next      = len_reg;
        ra_next       = ra_reg;
        cur_next      = cur_reg;
        end_next      = end_reg;
        oth_next      = oth_reg;
        addr_next     = addr_reg;
        rd_ok_next    = rd_ok_reg;
        res_data_next = res_data_reg;
        res_drew_next = res_drew_reg;
        m_data_next   = m_data_reg;
        m_drew_next   = m_drew_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        // Take configuration writes at any time
        if (cfg_valid)
        begin
            if (cfg_index == CFG_WIDTH)
            begin
                width_next = cfg_data;
            end
            else if (cfg_index == CFG_HEIGHT)
            begin
                height_next = cfg_data[6:0];
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                addr_next = addr_sum[AW-1:0];
                if (addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    cmd_next      = s_tuser[1:0];
                    x_next        = s_tdata[15:0];
                    y_next        = s_tdata[31:16];
                    len_next      = s_tdata[47:32];
                    mode_next     = s_tdata[49:48];
                    ra_next       = s_tdata[59:50];
                    res_data_next = 8'h00;
                    res_drew_next = 1'b0;
                    state_next    = ST_CLIP;
                end
            end
            ST_CLIP:
            begin
                addr_next  = ra_wide[AW-1:0];
                rd_ok_next = (32'(ra_reg) < DEPTH);
                cur_next   = start_s[7:0];
                end_next   = hi_s[7:0];
                oth_next   = o_s[7:0];
                if (cmd_reg == CMD_READ)
                begin
                    state_next = ST_RD;
                end
                else if (draw_ok)
                begin
                    res_drew_next = 1'b1;
                    state_next    = ST_BASE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_BASE:
            begin
                addr_next  = base_sum[AW-1:0];
                state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    res_data_next = rd_ok_reg ? ram_rdata : 8'h00;
                    state_next    = ST_DONE;
                end
                else if (cur_adv < {1'b0, end_reg})
                begin
                    // Advance to the next byte of the line
                    cur_next   = cur_adv[7:0];
                    addr_next  = addr_sum[AW-1:0];
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the result register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_data_next   = res_data_reg;
                    m_drew_next   = res_drew_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            width_reg    <= WIDTH_RST;
            height_reg   <= HEIGHT_RST;
            addr_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_data_reg   <= 8'h00;
            m_drew_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            addr_reg     <= addr_next;
            m_tvalid_reg <= m_tvalid_next;
            m_data_reg   <= m_data_next;
            m_drew_reg   <= m_drew_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        mode_reg     <= mode_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        len_reg      <= len_next;
        ra_reg       <= ra_next;
        cur_reg      <= cur_next;
        end_reg      <= end_next;
        oth_reg      <= oth_next;
        rd_ok_reg    <= rd_ok_next;
        res_data_reg <= res_data_next;
        res_drew_reg <= res_drew_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-9){1'b0}}, m_drew_reg, m_data_reg};

    // One command in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_tready)
        else $error("command accepted while another is in work");

    // Clipped drawing never writes beyond the store
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(addr_reg) < DEPTH))
        else $error("store write address out of range");

    // A result carries either read data or a drawn flag, never both
    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[8] && (m_tdata[7:0] != 8'h00)))
        else $error("read data and drawn flag both set");

    // No command is taken and the store is not read during the clearing pass
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready && !ram_re)
        else $error("store access during clearing pass");

endmodule

// ----- rtl/pfb_ram.sv -----
// Generic simple dual-port RAM with registered read.
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the page frame buffer line fill unit, with its own store image.
`timescale 1ns / 100ps

module testbench;
    import pfb_pkg::*;

    localparam int FB_COLS      = 128;
    localparam int FB_ROWS      = 64;
    localparam int FB_BYTES     = FB_COLS * ((FB_ROWS + 7) / 8);
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 160;

    // Codes that the package leaves unnamed
    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [1:0] CFG_SPARE  = 2'd3;

    typedef struct {
        logic [1:0]         op;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic signed [15:0] length;
        logic [1:0]         color_mode;
        logic [9:0]         read_address;
    } line_cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       drew_any;
    } fb_result_t;

    // Shadow of the frame store and registers; predicts and checks each result beat
    class frame_shadow;
        logic [7:0] store_image [FB_BYTES];
        logic [7:0] width_reg;
        logic [6:0] height_reg;
        fb_result_t pending_results [$];
        int         fail_count;

        function new();
            foreach (store_image[i])
                store_image[i] = 8'h00;
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            fail_count = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [7:0] value);
            if (idx == CFG_WIDTH)
                width_reg = value;
            else if (idx == CFG_HEIGHT)
                height_reg = value[6:0];
        endfunction

        // Registers above range are clamped to the store geometry
        function int used_columns();
            return (width_reg > FB_COLS) ? FB_COLS : int'(width_reg);
        endfunction

        function int used_rows();
            return (height_reg > FB_ROWS) ? FB_ROWS : int'(height_reg);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void paint(int idx, logic [7:0] mask, logic [1:0] mode);
            if (idx < 0 || idx >= FB_BYTES)
                return;
            case (mode)
                MODE_SET: store_image[idx] = store_image[idx] | mask;
                MODE_CLR: store_image[idx] = store_image[idx] & ~mask;
                default:  store_image[idx] = store_image[idx] ^ mask;
            endcase
        endfunction

        // One bit in each column byte along the row
        function bit draw_row(int x, int y, int len, logic [1:0] mode);
            int         w;
            int         h;
            int         base;
            int         i;
            logic [7:0] mask;
            w = used_columns();
            h = used_rows();
            if (y < 0 || y >= h)
                return 1'b0;
            if (x < 0)
            begin
                len = len + x;
                x = 0;
            end
            if (x + len > w)
                len = w - x;
            if (len <= 0)
                return 1'b0;
            base = (y / 8) * w + x;
            mask = 8'h01 << (y % 8);
            for (i = 0; i < len; i++)
                paint(base + i, mask, mode);
            return 1'b1;
        endfunction

        // Head mask, solid pages, tail mask down one column
        function bit draw_column(int x, int y, int len, logic [1:0] mode);
            int         w;
            int         h;
            int         y_end;
            int         page;
            int         top;
            int         lo;
            int         hi;
            logic [7:0] head;
            logic [7:0] tail;
            w = used_columns();
            h = used_rows();
            if (x < 0 || x >= w)
                return 1'b0;
            if (y < 0)
            begin
                len = len + y;
                y = 0;
            end
            if (y + len > h)
                len = h - y;
            if (len <= 0)
                return 1'b0;
            y_end = y + len;
            for (page = y / 8; page * 8 < y_end; page++)
            begin
                top  = page * 8;
                lo   = ((y > top) ? y : top) - top;
                hi   = ((y_end < top + 8) ? y_end : top + 8) - top;
                head = 8'hFF << lo;
                tail = 8'hFF >> (8 - hi);
                paint(page * w + x, head & tail, mode);
            end
            return 1'b1;
        endfunction

        // Apply an accepted command and queue the result it must produce
        function void note_command(line_cmd_t c);
            fb_result_t res;
            res = '0;
            if (c.op == CMD_READ)
                res.read_data = (int'(c.read_address) < FB_BYTES) ? store_image[c.read_address]
                                                                   : 8'h00;
            else if (c.op == CMD_HLINE && c.color_mode != MODE_SPARE)
                res.drew_any = draw_row(c.x_pos, c.y_pos, c.length, c.color_mode);
            else if (c.op == CMD_VLINE && c.color_mode != MODE_SPARE)
                res.drew_any = draw_column(c.x_pos, c.y_pos, c.length, c.color_mode);
            pending_results.push_back(res);
        endfunction

        function void compare_beat(logic [M_TDATA_W-1:0] beat);
            fb_result_t want;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $error("result beat with nothing pending: tdata %h", beat);
                return;
            end
            want = pending_results.pop_front();
            if (beat[7:0] !== want.read_data)
            begin
                fail_count++;
                $error("read_data: expected %0d, actual %0d", want.read_data, beat[7:0]);
            end
            if (beat[8] !== want.drew_any)
            begin
                fail_count++;
                $error("drew_any: expected %0d, actual %0d", want.drew_any, beat[8]);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    frame_shadow shadow = new();

    page_framebuffer_line_fill_unit #(
        .MAX_WIDTH  (FB_COLS),
        .MAX_HEIGHT (FB_ROWS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Check every result beat taken at a rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            shadow.compare_beat(m_tdata);
    end

    // Stall the result side with a repeating 16-bit ready pattern, drawn anew when the slot count wraps
    initial
    begin : result_sink
        logic [15:0] stall_pattern;
        int          slot;
        stall_pattern = 16'hFFFF;
        slot = 0;
        forever
        begin
            @(posedge clk);
            if (slot == 0)
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                            : (16'($urandom) | 16'h0101);
            m_tready <= stall_pattern[slot % 16];
            slot = (slot + 1) % 128;
        end
    end

    function automatic line_cmd_t make_command(logic [1:0] op, int x, int y, int len,
                                               logic [1:0] mode, int addr);
        line_cmd_t c;
        c.op           = op;
        c.x_pos        = 16'(x);
        c.y_pos        = 16'(y);
        c.length       = 16'(len);
        c.color_mode   = mode;
        c.read_address = 10'(addr);
        return c;
    endfunction

    // Mostly coordinates near the display, now and then any 16-bit value
    function automatic line_cmd_t random_command(int cols, int rows);
        line_cmd_t c;
        int        pick;
        int        span;
        int        pages;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            c.op = CMD_HLINE;
        else if (pick < 70)
            c.op = CMD_VLINE;
        else if (pick < 96)
            c.op = CMD_READ;
        else
            c.op = CMD_SPARE;
        c.color_mode = ($urandom_range(0, 24) == 0) ? MODE_SPARE
                                                    : 2'($urandom_range(MODE_SET, MODE_INV));
        span = (cols > 0) ? cols : 1;
        c.x_pos = ($urandom_range(0, 6) == 0) ? 16'($urandom)
                                              : 16'(int'($urandom_range(0, span + 40)) - 20);
        span = (rows > 0) ? rows : 1;
        c.y_pos = ($urandom_range(0, 6) == 0) ? 16'($urandom)
                                              : 16'(int'($urandom_range(0, span + 40)) - 20);
        c.length = ($urandom_range(0, 6) == 0) ? 16'($urandom)
                                               : 16'(int'($urandom_range(0, 150)) - 12);
        pages = (rows + 7) / 8;
        if (cols > 0 && rows > 0 && $urandom_range(0, 3) != 0)
            c.read_address = 10'($urandom_range(0, cols * pages - 1));
        else
            c.read_address = 10'($urandom_range(0, 1023));
        return c;
    endfunction

    // Present one command and hold it until the beat is taken; valid stays high
    task automatic send_command(input line_cmd_t c);
        s_tdata  <= {4'b0000, c.read_address, c.color_mode, c.length, c.y_pos, c.x_pos};
        s_tuser  <= c.op;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        shadow.note_command(c);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow.write_register(idx, value);
    endtask

    task automatic wait_for_drain();
        while (shadow.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random commands in bursts of random length with random gaps between
    task automatic run_traffic(input int count);
        int sent;
        int burst;
        int gap;
        int k;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && sent < count; k++)
            begin
                send_command(random_command(shadow.used_columns(), shadow.used_rows()));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int         phase;
        logic [7:0] cols;
        logic [7:0] rows;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed commands on the reset geometry of 128 by 64
        send_command(make_command(CMD_HLINE, 0, 0, 128, MODE_SET, 0));
        send_command(make_command(CMD_READ, 0, 0, 0, MODE_SET, 0));
        send_command(make_command(CMD_READ, 0, 0, 0, MODE_SET, 127));
        send_command(make_command(CMD_HLINE, -10, 63, 20, MODE_INV, 0));
        send_command(make_command(CMD_READ, 0, 0, 0, MODE_SET, 905));
        send_command(make_command(CMD_HLINE, -32768, 5, 32767, MODE_SET, 0));
        send_command(make_command(CMD_HLINE, 32767, 0, 32767, MODE_SET, 0));
        send_command(make_command(CMD_HLINE, 120, 7, 32767, MODE_CLR, 0));
        send_command(make_command(CMD_HLINE, 0, -32768, 50, MODE_SET, 0));
        send_command(make_command(CMD_HLINE, 0, 32767, 50, MODE_SET, 0));
        send_command(make_command(CMD_VLINE, 5, -3, 20, MODE_SET, 0));
        send_command(make_command(CMD_VLINE, 127, 3, 2, MODE_INV, 0));
        send_command(make_command(CMD_VLINE, 10, 0, 64, MODE_SET, 0));
        send_command(make_command(CMD_VLINE, 10, 8, 48, MODE_CLR, 0));
        send_command(make_command(CMD_VLINE, -1, 0, 10, MODE_SET, 0));
        send_command(make_command(CMD_VLINE, 128, 0, 10, MODE_SET, 0));
        send_command(make_command(CMD_VLINE, 5, -32768, 32767, MODE_SET, 0));
        send_command(make_command(CMD_VLINE, 20, 4, -32768, MODE_SET, 0));
        send_command(make_command(CMD_HLINE, 3, 9, 0, MODE_SET, 0));
        send_command(make_command(CMD_HLINE, 0, 9, 40, MODE_SPARE, 0));
        send_command(make_command(CMD_SPARE, 0, 9, 40, MODE_SET, 5));
        send_command(make_command(CMD_READ, 0, 0, 0, MODE_SET, 5));
        send_command(make_command(CMD_READ, 0, 0, 0, MODE_SET, 261));
        send_command(make_command(CMD_READ, 0, 0, 0, MODE_SET, 127));
        send_command(make_command(CMD_READ, 0, 0, 0, MODE_SET, 394));
        send_command(make_command(CMD_READ, 0, 0, 0, MODE_SET, 1023));
        s_tvalid <= 1'b0;

        // Random traffic over a range of display geometries
        for (phase = 0; phase < 8; phase++)
        begin
            wait_for_drain();
            case (phase)
                0: begin cols = 8'd1;   rows = 8'd1;   end
                1: begin cols = 8'd255; rows = 8'hFF;  end
                2: begin cols = 8'd0;   rows = 8'd64;  end
                3: begin cols = 8'd128; rows = 8'd0;   end
                4: begin cols = 8'd37;  rows = 8'd21;  end
                5: begin cols = 8'($urandom_range(1, 128)); rows = 8'($urandom_range(1, 64)); end
                6: begin cols = 8'd128; rows = 8'd64;  end
                default: begin cols = 8'd200; rows = 8'd8; end
            endcase
            write_register(CFG_WIDTH, cols);
            write_register(CFG_HEIGHT, rows);
            if (phase == 7)
                write_register(CFG_SPARE, 8'($urandom));
            cfg_valid <= 1'b0;
            run_traffic(PHASE_ITEMS);
        end

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (shadow.fail_count == 0 && shadow.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
